[hdl/riot_pkg.sv]
// ----------------------------------------------------------------------------
// riot_pkg
// Shared types, register offsets and timer constants for the ports and
// interval timer block.
// ----------------------------------------------------------------------------
package riot_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [1:0] REG_PORT_A = 2'd0;
  localparam logic [1:0] REG_DIR_A  = 2'd1;
  localparam logic [1:0] REG_PORT_B = 2'd2;
  localparam logic [1:0] REG_DIR_B  = 2'd3;

  localparam logic [2:0] ADDR_TIMER     = 3'd4;
  localparam logic [2:0] ADDR_FLAG      = 3'd5;
  localparam logic [2:0] ADDR_TIMER_ALT = 3'd6;
  localparam logic [2:0] ADDR_FLAG_ALT  = 3'd7;

  localparam int unsigned ADDR_SEL_BIT   = 2;
  localparam int unsigned ADDR_LOAD_BIT  = 4;
  localparam int unsigned ADDR_FLAGS_BIT = 0;

  localparam logic [7:0] FLAG_BYTE = 8'h80;
  localparam logic [7:0] ALL_HIGH  = 8'hFF;

  localparam int unsigned COUNT_W = 19;

  localparam logic signed [COUNT_W-1:0] COUNT_FLOOR    = -19'sd257;
  localparam logic signed [COUNT_W-1:0] COUNT_READ_MIN = -19'sd256;
  localparam logic signed [COUNT_W-1:0] COUNT_NEG_ONE  = -19'sd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] address;
    logic [7:0] write_data;
    logic [7:0] port_a_in;
    logic [7:0] port_b_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       timer_flag;
  } result_t;

  typedef struct packed {
    logic [7:0] rd_port;
    logic [7:0] a_drive;
    logic [7:0] b_drive;
  } port_stat_t;

  typedef struct packed {
    logic [7:0] rd_timer;
    logic       flag_now;
    logic       flag_next;
  } timer_stat_t;

  function automatic logic [3:0] prescale_of(input logic [1:0] sel);
    logic [3:0] s;
    case (sel)
      2'd0:    s = 4'd0;
      2'd1:    s = 4'd3;
      2'd2:    s = 4'd6;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] mix_bits(input logic [7:0] dir, input logic [7:0] latch,
                                          input logic [7:0] pins);
    return (dir & latch) | (~dir & pins);
  endfunction

endpackage

[hdl/riot_ports_and_interval_timer_core.sv]
// ----------------------------------------------------------------------------
// riot_ports_and_interval_timer_core
// Two I/O ports with direction registers and an interval timer.
// A beat is held in the input register, then moves to the result register.
// Throughput: one beat per cycle unless stalled, set by input and result registers.
// State updates as a beat passes from the input register to the result register.
// Reset clears latches, directions, prescale, flag and count at once.
// ----------------------------------------------------------------------------
module riot_ports_and_interval_timer_core import riot_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic        in_full;
  item_t       in_reg;
  logic        advance;
  logic        step;
  port_stat_t  port_stat;
  timer_stat_t timer_stat;
  logic [7:0]  rd_byte;

  assign advance    = !result_valid || result_ready;
  assign step       = in_full && advance;
  assign item_ready = !in_full || advance;

  riot_ports u_ports (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .stat (port_stat)
  );

  riot_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .stat (timer_stat)
  );

  always_comb begin
    rd_byte = '0;
    if (in_reg.mode == MODE_READ) begin
      unique case (in_reg.address[2:0]) inside
        ADDR_TIMER, ADDR_TIMER_ALT: rd_byte = timer_stat.rd_timer;
        ADDR_FLAG, ADDR_FLAG_ALT:   rd_byte = timer_stat.flag_now ? FLAG_BYTE : 8'h00;
        default:                    rd_byte = port_stat.rd_port;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) in_reg <= item;
    if (step) begin
      result.read_data  <= rd_byte;
      result.port_a_out <= port_stat.a_drive;
      result.port_b_out <= port_stat.b_drive;
      result.timer_flag <= timer_stat.flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_reg)))
    else $error("input register lost a stalled beat");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (step && in_reg.mode != MODE_READ) |=> (result.read_data == 8'h00))
    else $error("read_data nonzero on a non-read beat");

  a_load_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (step && in_reg.mode == MODE_WRITE && in_reg.address[ADDR_SEL_BIT]
     && in_reg.address[ADDR_LOAD_BIT]) |=> !result.timer_flag)
    else $error("timer flag set right after a timer load");
`endif

endmodule

[hdl/riot_ports.sv]
// ----------------------------------------------------------------------------
// riot_ports
// Port A and port B data latches and direction registers, with the read
// mix of driven bits and pin levels.
// ----------------------------------------------------------------------------
module riot_ports import riot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  output port_stat_t stat
);

  logic [7:0] latch_a, latch_a_next;
  logic [7:0] latch_b, latch_b_next;
  logic [7:0] dir_a, dir_a_next;
  logic [7:0] dir_b, dir_b_next;

  always_comb begin
    latch_a_next = latch_a;
    latch_b_next = latch_b;
    dir_a_next   = dir_a;
    dir_b_next   = dir_b;
    if (item.mode == MODE_WRITE && !item.address[ADDR_SEL_BIT]) begin
      unique case (item.address[1:0])
        REG_PORT_A: latch_a_next = item.write_data;
        REG_DIR_A:  dir_a_next   = item.write_data;
        REG_PORT_B: latch_b_next = item.write_data;
        REG_DIR_B:  dir_b_next   = item.write_data;
        default:    dir_b_next   = item.write_data;
      endcase
    end
  end

  always_comb begin
    unique case (item.address[1:0])
      REG_PORT_A: stat.rd_port = mix_bits(dir_a, latch_a, item.port_a_in);
      REG_DIR_A:  stat.rd_port = dir_a;
      REG_PORT_B: stat.rd_port = mix_bits(dir_b, latch_b, item.port_b_in);
      REG_DIR_B:  stat.rd_port = dir_b;
      default:    stat.rd_port = dir_b;
    endcase
    stat.a_drive = mix_bits(dir_a_next, latch_a_next, ALL_HIGH);
    stat.b_drive = mix_bits(dir_b_next, latch_b_next, ALL_HIGH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a <= '0;
      latch_b <= '0;
      dir_a   <= '0;
      dir_b   <= '0;
    end else if (step) begin
      latch_a <= latch_a_next;
      latch_b <= latch_b_next;
      dir_a   <= dir_a_next;
      dir_b   <= dir_b_next;
    end
  end

endmodule

[hdl/riot_timer.sv]
// ----------------------------------------------------------------------------
// riot_timer
// Interval timer: prescaled load, tick countdown with floor, timer read
// value and underflow flag.
// ----------------------------------------------------------------------------
module riot_timer import riot_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  output timer_stat_t stat
);

  logic signed [COUNT_W-1:0] count, count_next;
  logic [3:0]                shift, shift_next;
  logic                      cleared, cleared_next;
  logic [COUNT_W-1:0]        count_shr;
  logic                      timer_rd;
  logic                      timer_ld;

  assign count_shr = $unsigned(count) >> shift;
  assign timer_rd  = item.mode == MODE_READ && item.address[ADDR_SEL_BIT]
                     && !item.address[ADDR_FLAGS_BIT];
  assign timer_ld  = item.mode == MODE_WRITE && item.address[ADDR_SEL_BIT]
                     && item.address[ADDR_LOAD_BIT];

  always_comb begin
    count_next   = count;
    shift_next   = shift;
    cleared_next = cleared;
    if (item.mode == MODE_TICK) begin
      if (count > COUNT_FLOOR) count_next = count - 19'sd1;
    end else if (timer_rd) begin
      if (count[COUNT_W-1] && count != COUNT_NEG_ONE) cleared_next = 1'b1;
    end else if (timer_ld) begin
      cleared_next = 1'b0;
      shift_next   = prescale_of(item.address[1:0]);
      count_next   = $signed({{(COUNT_W-8){1'b0}}, item.write_data} << shift_next);
    end
  end

  always_comb begin
    if (!count[COUNT_W-1]) begin
      stat.rd_timer = count_shr[7:0];
    end else if (count >= COUNT_READ_MIN) begin
      stat.rd_timer = count[7:0];
    end else begin
      stat.rd_timer = '0;
    end
    stat.flag_now  = count[COUNT_W-1] && !cleared;
    stat.flag_next = count_next[COUNT_W-1] && !cleared_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      shift   <= '0;
      cleared <= 1'b0;
    end else if (step) begin
      count   <= count_next;
      shift   <= shift_next;
      cleared <= cleared_next;
    end
  end

endmodule

[bench/riot_ports_and_interval_timer_core_tb.sv]
// ----------------------------------------------------------------------------
// riot_ports_and_interval_timer_core_tb
// Self-checking bench for the ports and interval timer core. A predictor
// models the port latches, direction registers and interval timer. Each
// accepted beat yields one expected result, and each result that comes back
// is compared field by field. A short directed run is followed by random
// timer segments: a timer load, then a run of ticks, reads, writes and no-ops
// that is long enough at times to reach the count floor. Both sides idle at
// random, the result side holds off once long enough to back the core up,
// and the sender pauses once until the core has drained.
// ----------------------------------------------------------------------------
module riot_ports_and_interval_timer_core_tb;
  import riot_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1250;

  class riot_predictor;
    logic [7:0] latch_a, latch_b, dir_a, dir_b;
    logic [3:0] shift;
    logic cleared;
    logic signed [COUNT_W-1:0] count;
    result_t pending_results[$];
    int unsigned mismatch_count;
    int unsigned result_index;

    function new();
      latch_a = '0;
      latch_b = '0;
      dir_a = '0;
      dir_b = '0;
      shift = '0;
      cleared = 1'b0;
      count = '0;
      mismatch_count = 0;
      result_index = 0;
    endfunction

    function void absorb_item(item_t it);
      result_t r;
      logic [7:0] rd;
      logic [COUNT_W-1:0] raw;
      rd = '0;
      case (it.mode)
        MODE_TICK: begin
          if (count > COUNT_FLOOR) count = count - 1'b1;
        end
        MODE_READ: begin
          if (!it.address[ADDR_SEL_BIT]) begin
            case (it.address[1:0])
              REG_PORT_A: rd = (dir_a & latch_a) | (~dir_a & it.port_a_in);
              REG_DIR_A:  rd = dir_a;
              REG_PORT_B: rd = (dir_b & latch_b) | (~dir_b & it.port_b_in);
              default:    rd = dir_b;
            endcase
          end else if (it.address[2:0] == ADDR_TIMER || it.address[2:0] == ADDR_TIMER_ALT) begin
            if (count >= 0) begin
              raw = count;
              raw = raw >> shift;
              rd = raw[7:0];
            end else begin
              if (count != COUNT_NEG_ONE) cleared = 1'b1;
              rd = (count >= COUNT_READ_MIN) ? count[7:0] : 8'h00;
            end
          end else begin
            rd = (count < 0 && !cleared) ? FLAG_BYTE : 8'h00;
          end
        end
        MODE_WRITE: begin
          if (it.address[ADDR_SEL_BIT]) begin
            if (it.address[ADDR_LOAD_BIT]) begin
              cleared = 1'b0;
              case (it.address[1:0])
                2'd0:    shift = 4'd0;
                2'd1:    shift = 4'd3;
                2'd2:    shift = 4'd6;
                default: shift = 4'd10;
              endcase
              raw = '0;
              raw[7:0] = it.write_data;
              raw = raw << shift;
              count = raw;
            end
          end else begin
            case (it.address[1:0])
              REG_PORT_A: latch_a = it.write_data;
              REG_DIR_A:  dir_a = it.write_data;
              REG_PORT_B: latch_b = it.write_data;
              default:    dir_b = it.write_data;
            endcase
          end
        end
        default: ;
      endcase
      r.read_data = rd;
      r.port_a_out = (dir_a & latch_a) | ~dir_a;
      r.port_b_out = (dir_b & latch_b) | ~dir_b;
      r.timer_flag = count < 0 && !cleared;
      pending_results.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      result_index++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected: rd=%h a=%h b=%h flag=%b",
                   result_index, got.read_data, got.port_a_out, got.port_b_out,
                   got.timer_flag);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.port_a_out !== want.port_a_out ||
          got.port_b_out !== want.port_b_out || got.timer_flag !== want.timer_flag) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: expected rd=%h a=%h b=%h flag=%b, got rd=%h a=%h b=%h flag=%b",
                   result_index, want.read_data, want.port_a_out, want.port_b_out,
                   want.timer_flag, got.read_data, got.port_a_out, got.port_b_out,
                   got.timer_flag);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;

  riot_predictor predictor;
  logic calm;
  logic stall_request;
  int unsigned useful_items;

  riot_ports_and_interval_timer_core DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic item_t mk(input logic [1:0] mode, input logic [4:0] addr,
                               input logic [7:0] data, input logic [7:0] pa,
                               input logic [7:0] pb);
    item_t it;
    it.mode = mode;
    it.address = addr;
    it.write_data = data;
    it.port_a_in = pa;
    it.port_b_in = pb;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    predictor.absorb_item(it);
    useful_items++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (predictor.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_segment(input int unsigned len);
    item_t it;
    int unsigned pick;
    logic [4:0] addr;
    logic [7:0] data;
    data = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    addr = {1'b1, 1'($urandom_range(1)), 1'b1, 2'($urandom_range(3))};
    send_item(mk(MODE_WRITE, addr, data, 8'($urandom), 8'($urandom)));
    for (int unsigned i = 0; i < len && useful_items < ITEM_TARGET; i++) begin
      pick = $urandom_range(99);
      addr = 5'($urandom);
      if (pick < 55) begin
        it = mk(MODE_TICK, addr, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        it = mk(MODE_READ, addr, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        if (addr[ADDR_SEL_BIT]) addr[ADDR_LOAD_BIT] = 1'b0;
        it = mk(MODE_WRITE, addr, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        it = mk(MODE_UNUSED, addr, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_item(it);
    end
  endtask

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) predictor.match_result(result);
      if (stall_request) begin
        stall_left = 250;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || $urandom_range(99) >= 32;
      end
    end
  end

  initial begin
    int unsigned seg;
    predictor = new();
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    calm = 1'b0;
    stall_request = 1'b0;
    useful_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(mk(MODE_READ, {3'b000, REG_PORT_A}, 8'h00, 8'hFF, 8'h00));
    send_item(mk(MODE_WRITE, {3'b000, REG_DIR_A}, 8'hFF, 8'h00, 8'hFF));
    send_item(mk(MODE_WRITE, {3'b000, REG_PORT_A}, 8'h00, 8'hFF, 8'h00));
    send_item(mk(MODE_WRITE, {3'b000, REG_PORT_B}, 8'hFF, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, {3'b010, REG_DIR_B}, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(MODE_WRITE, {3'b000, REG_PORT_B}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, {3'b000, REG_DIR_A}, 8'hF0, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, {3'b000, REG_PORT_A}, 8'hA5, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, {3'b000, REG_DIR_B}, 8'h0F, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {3'b000, REG_PORT_A}, 8'h00, 8'h0F, 8'hF0));
    send_item(mk(MODE_READ, {3'b110, REG_DIR_A}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {3'b010, REG_PORT_B}, 8'h00, 8'hFF, 8'hFF));
    send_item(mk(MODE_READ, {3'b100, REG_DIR_B}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, 5'b10100, 8'h01, 8'h00, 8'h00));
    send_item(mk(MODE_TICK, 5'b00000, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_TICK, 5'b11111, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(MODE_READ, {2'b00, ADDR_TIMER}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b00, ADDR_FLAG}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_TICK, 5'b00000, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b11, ADDR_TIMER_ALT}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b01, ADDR_FLAG_ALT}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, 5'b11111, 8'hFF, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b00, ADDR_TIMER}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, 5'b10101, 8'h80, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b10, ADDR_TIMER_ALT}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, 5'b10110, 8'hFF, 8'h00, 8'h00));
    send_item(mk(MODE_READ, {2'b00, ADDR_TIMER}, 8'h00, 8'h00, 8'h00));
    send_item(mk(MODE_WRITE, 5'b00100, 8'h55, 8'h00, 8'h00));
    send_item(mk(MODE_UNUSED, 5'b10101, 8'hAA, 8'hFF, 8'hFF));

    seg = 0;
    useful_items = 0;
    while (useful_items < ITEM_TARGET) begin
      calm = (seg == 1);
      if (seg == 2) stall_request = 1'b1;
      if (seg == 4) drain();
      if (calm || $urandom_range(99) < 30) run_segment($urandom_range(700, 300));
      else run_segment($urandom_range(120, 5));
      seg++;
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (predictor.mismatch_count == 0 && predictor.pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
